// ----- hw/rtl/binary_object_stream_tokenizer_assert.svh -----
// assertion macros shared by the tokenizer
`ifndef BINARY_OBJECT_STREAM_TOKENIZER_ASSERT_SVH
`define BINARY_OBJECT_STREAM_TOKENIZER_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define BOST_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tokenizer check failed");

// same check, but also active during reset
`define BOST_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("tokenizer check failed");

`endif

// ----- hw/rtl/bost_pkg.sv -----
package bost_pkg;

   localparam int MAX_NEST  = 16;
   localparam int STACK_AW  = $clog2(MAX_NEST);
   localparam logic [4:0] MAX_NEST_V = 5'(MAX_NEST);
   localparam logic [27:0] MASK28 = 28'hFFF_FFFF;

   typedef enum logic [2:0] {
      ROLE_HEADER  = 3'd0,
      ROLE_LENGTH  = 3'd1,
      ROLE_PAYLOAD = 3'd2,
      ROLE_SCALAR  = 3'd3,
      ROLE_KEY     = 3'd4,
      ROLE_KEY_END = 3'd5
   } role_type;

   typedef enum logic [3:0] {
      KIND_NULL     = 4'd0,
      KIND_TRUE     = 4'd1,
      KIND_FALSE    = 4'd2,
      KIND_BYTE     = 4'd3,
      KIND_I32      = 4'd4,
      KIND_I64      = 4'd5,
      KIND_U32      = 4'd6,
      KIND_U64      = 4'd7,
      KIND_DOUBLE   = 4'd8,
      KIND_DATETIME = 4'd9,
      KIND_MAP      = 4'd10,
      KIND_LIST     = 4'd11,
      KIND_END      = 4'd12,
      KIND_STRING   = 4'd13,
      KIND_BLOB     = 4'd14,
      KIND_BAD      = 4'd15
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE   = 2'd0,
      ERR_TOKEN  = 2'd1,
      ERR_LENGTH = 2'd2,
      ERR_NEST   = 2'd3
   } err_type;

   typedef enum logic [2:0] {
      PH_HDR  = 3'd0,
      PH_LEN  = 3'd1,
      PH_PAY  = 3'd2,
      PH_SCAL = 3'd3,
      PH_KEY  = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      HC_SHORT_TEXT = 2'd0,
      HC_LONG_TEXT  = 2'd1,
      HC_LONG_BAD   = 2'd2,
      HC_SMALL      = 2'd3
   } hdr_class_type;

   localparam logic [7:0] B_END  = 8'h00;
   localparam logic [7:0] B_MAP  = 8'h0C;
   localparam logic [7:0] B_LIST = 8'h0D;

   typedef struct packed {
      hdr_class_type hclass;
      kind_type      small_kind;
      logic [3:0]    small_size;
      kind_type      text_kind;
   } hdr_info_type;

   typedef struct packed {
      logic [7:0]   data;
      logic         doc_start;
      hdr_info_type info;
   } item_type;

   typedef struct packed {
      logic         doc_done;
      err_type      error_code;
      logic [4:0]   nest_level;
      logic         container_end;
      logic         value_done;
      logic [63:0]  scalar_value;
      logic [27:0]  payload_length;
      kind_type     token_kind;
      role_type     byte_role;
   } rsp_type;

   function automatic kind_type small_kind_of(input logic [3:0] n);
      kind_type k;
      unique case (n)
         4'h0: k = KIND_END;
         4'h1: k = KIND_NULL;
         4'h2: k = KIND_TRUE;
         4'h3: k = KIND_FALSE;
         4'h4: k = KIND_BYTE;
         4'h5: k = KIND_I32;
         4'h6: k = KIND_I64;
         4'h7: k = KIND_U32;
         4'h8: k = KIND_U64;
         4'hA: k = KIND_DOUBLE;
         4'hB: k = KIND_DATETIME;
         4'hC: k = KIND_MAP;
         4'hD: k = KIND_LIST;
         default: k = KIND_BAD;
      endcase
      return k;
   endfunction

   function automatic logic [3:0] small_size_of(input logic [3:0] n);
      logic [3:0] s;
      unique case (n)
         4'h4: s = 4'd1;
         4'h5, 4'h7: s = 4'd4;
         4'h6, 4'h8, 4'hA, 4'hB: s = 4'd8;
         default: s = 4'd0;
      endcase
      return s;
   endfunction

   function automatic kind_type text_kind_of(input logic [7:0] h);
      return h[6] ? KIND_STRING : KIND_BLOB;
   endfunction

endpackage

// ----- hw/rtl/bost_front.sv -----
module bost_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [7:0]         in_data,
   input  logic               in_doc_start,
   output logic               out_valid,
   input  logic               out_ready,
   output bost_pkg::item_type out_item
);
   import bost_pkg::*;

   // two-entry queue of classified bytes
   item_type   q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic       push, pop;
   item_type   new_item;

   always_comb begin
      new_item.data       = in_data;
      new_item.doc_start  = in_doc_start;
      new_item.info.small_kind = small_kind_of(in_data[3:0]);
      new_item.info.small_size = small_size_of(in_data[3:0]);
      new_item.info.text_kind  = text_kind_of(in_data);
      priority if (in_data[7]) begin
         new_item.info.hclass = HC_SHORT_TEXT;
      end else if (in_data[6:4] == 3'b000) begin
         new_item.info.hclass = HC_SMALL;
      end else if (in_data[5:4] == 2'b00) begin
         new_item.info.hclass = HC_LONG_BAD;
      end else begin
         new_item.info.hclass = HC_LONG_TEXT;
      end
   end

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_item  = q_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= new_item;
      end
   end

endmodule

// ----- hw/rtl/bost_back.sv -----
module bost_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  bost_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output bost_pkg::rsp_type  out_rsp
);
   import bost_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  hdr_ff, hdr_in;
   logic [27:0] rem_ff, rem_in;
   logic [1:0]  lbl_ff, lbl_in;
   logic [63:0] acc_ff, acc_in;
   logic [3:0]  vbl_ff, vbl_in;
   logic [4:0]  depth_ff, depth_in;
   err_type     err_ff, err_in;
   logic        stack_ff [MAX_NEST];
   logic        valid_ff, valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic                stack_we, stack_wd;
   logic [STACK_AW-1:0] stack_wa;
   logic                take;

   // state seen by this byte, after an optional document restart
   phase_type   ph;
   logic [7:0]  hdr;
   logic [27:0] rem;
   logic [1:0]  lbl;
   logic [63:0] acc;
   logic [3:0]  vbl;
   logic [4:0]  depth;
   err_type     err;
   logic [7:0]  b;
   logic        fin;
   logic [1:0]  lk;
   logic [2:0]  sk;
   logic [4:0]  dtop;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

   always_comb begin
      b     = in_item.data;
      ph    = in_item.doc_start ? PH_HDR   : phase_ff;
      hdr   = in_item.doc_start ? 8'h00    : hdr_ff;
      rem   = in_item.doc_start ? 28'd0    : rem_ff;
      lbl   = in_item.doc_start ? 2'd0     : lbl_ff;
      acc   = in_item.doc_start ? 64'd0    : acc_ff;
      vbl   = in_item.doc_start ? 4'd0     : vbl_ff;
      depth = in_item.doc_start ? 5'd0     : depth_ff;
      err   = in_item.doc_start ? ERR_NONE : err_ff;

      phase_in = ph;
      hdr_in   = hdr;
      rem_in   = rem;
      lbl_in   = lbl;
      acc_in   = acc;
      vbl_in   = vbl;
      depth_in = depth;
      err_in   = err;
      fin      = 1'b0;
      stack_we = 1'b0;
      stack_wa = depth[STACK_AW-1:0];
      stack_wd = 1'b0;
      lk       = 2'(hdr[5:4] - lbl);
      sk       = 3'(small_size_of(hdr[3:0]) - vbl);

      rsp_in                = '0;
      rsp_in.byte_role      = ROLE_HEADER;
      rsp_in.token_kind     = KIND_NULL;
      rsp_in.error_code     = ERR_NONE;

      if (err != ERR_NONE) begin
         rsp_in.error_code = err;
      end else begin
         unique case (ph)
            PH_HDR: begin
               hdr_in = b;
               unique case (in_item.info.hclass)
                  HC_SHORT_TEXT: begin
                     rsp_in.token_kind     = in_item.info.text_kind;
                     rsp_in.payload_length = {22'd0, b[5:0]};
                     if (b[5:0] != 6'd0) begin
                        acc_in   = {58'd0, b[5:0]};
                        rem_in   = {22'd0, b[5:0]};
                        phase_in = PH_PAY;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  HC_LONG_BAD: begin
                     rsp_in.error_code = ERR_LENGTH;
                     err_in = ERR_LENGTH;
                  end
                  HC_LONG_TEXT: begin
                     rsp_in.token_kind = in_item.info.text_kind;
                     rem_in   = {24'd0, b[3:0]};
                     lbl_in   = b[5:4];
                     phase_in = PH_LEN;
                  end
                  HC_SMALL: begin
                     priority if (in_item.info.small_kind == KIND_BAD) begin
                        rsp_in.error_code = ERR_TOKEN;
                        err_in = ERR_TOKEN;
                     end else if (b == B_END) begin
                        rsp_in.token_kind = KIND_END;
                        if (depth == 5'd0) begin
                           rsp_in.doc_done = 1'b1;
                        end else begin
                           depth_in = depth - 5'd1;
                           rsp_in.container_end = 1'b1;
                           fin = 1'b1;
                        end
                     end else if (b == B_MAP || b == B_LIST) begin
                        if (depth >= MAX_NEST_V) begin
                           rsp_in.error_code = ERR_NEST;
                           err_in = ERR_NEST;
                        end else begin
                           rsp_in.token_kind = in_item.info.small_kind;
                           stack_we = 1'b1;
                           stack_wd = (b == B_MAP);
                           depth_in = depth + 5'd1;
                        end
                     end else begin
                        rsp_in.token_kind = in_item.info.small_kind;
                        if (in_item.info.small_size != 4'd0) begin
                           acc_in   = 64'd0;
                           vbl_in   = in_item.info.small_size;
                           phase_in = PH_SCAL;
                        end else begin
                           fin = 1'b1;
                        end
                     end
                  end
                  default: ;
               endcase
            end
            PH_LEN: begin
               rsp_in.byte_role  = ROLE_LENGTH;
               rsp_in.token_kind = text_kind_of(hdr);
               unique case (lk)
                  2'd0: rem_in = rem | {16'd0, b, 4'd0};
                  2'd1: rem_in = rem | {8'd0, b, 12'd0};
                  2'd2: rem_in = rem | {b, 20'd0};
                  default: rem_in = rem;
               endcase
               rem_in = rem_in & MASK28;
               lbl_in = lbl - 2'd1;
               if (lbl_in == 2'd0) begin
                  rsp_in.payload_length = rem_in;
                  if (rem_in == 28'd0) begin
                     fin = 1'b1;
                  end else begin
                     acc_in   = {36'd0, rem_in};
                     phase_in = PH_PAY;
                  end
               end
            end
            PH_PAY: begin
               rsp_in.byte_role      = ROLE_PAYLOAD;
               rsp_in.token_kind     = text_kind_of(hdr);
               rsp_in.payload_length = acc[27:0];
               rem_in = rem - 28'd1;
               if (rem_in == 28'd0) begin
                  fin = 1'b1;
               end
            end
            PH_SCAL: begin
               rsp_in.byte_role  = ROLE_SCALAR;
               rsp_in.token_kind = small_kind_of(hdr[3:0]);
               // or the byte into its lane
               for (int i = 0; i < 8; i++) begin
                  if (sk == 3'(i)) begin
                     acc_in[8*i +: 8] = acc[8*i +: 8] | b;
                  end
               end
               rsp_in.scalar_value = acc_in;
               vbl_in = vbl - 4'd1;
               if (vbl_in == 4'd0) begin
                  fin = 1'b1;
               end
            end
            PH_KEY: begin
               if (b == 8'h00) begin
                  rsp_in.byte_role = ROLE_KEY_END;
                  phase_in = PH_HDR;
               end else begin
                  rsp_in.byte_role = ROLE_KEY;
               end
            end
            default: ;
         endcase
      end

      // value completion picks the next phase from the enclosing container
      dtop = depth_in - 5'd1;
      if (fin) begin
         rsp_in.value_done = 1'b1;
         if (depth_in == 5'd0) begin
            rsp_in.doc_done = 1'b1;
            phase_in = PH_HDR;
         end else if (stack_ff[dtop[STACK_AW-1:0]]) begin
            phase_in = PH_KEY;
         end else begin
            phase_in = PH_HDR;
         end
      end
      rsp_in.nest_level = depth_in;

      valid_in = take ? 1'b1 : (out_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         phase_ff <= PH_HDR;
         hdr_ff   <= 8'h00;
         rem_ff   <= 28'd0;
         lbl_ff   <= 2'd0;
         acc_ff   <= 64'd0;
         vbl_ff   <= 4'd0;
         depth_ff <= 5'd0;
         err_ff   <= ERR_NONE;
      end else begin
         valid_ff <= valid_in;
         if (take) begin
            phase_ff <= phase_in;
            hdr_ff   <= hdr_in;
            rem_ff   <= rem_in;
            lbl_ff   <= lbl_in;
            acc_ff   <= acc_in;
            vbl_ff   <= vbl_in;
            depth_ff <= depth_in;
            err_ff   <= err_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
      if (take && stack_we) begin
         stack_ff[stack_wa] <= stack_wd;
      end
   end

endmodule

// ----- hw/rtl/binary_object_stream_tokenizer.sv -----
// Byte-serial tokenizer for a compact tagged binary object stream. Each byte
// transfer on req_ produces exactly one rsp_ transfer naming the byte's role
// (header, length extension, payload, scalar byte, key char, key end), its
// token kind, decoded length, assembled scalar bits, completion flags, nesting
// depth and a sticky error code that holds until a byte with doc_start set.
// Throughput is one byte per clock while neither side stalls; a byte passes
// the classify queue, then the registered state update of the back end, whose
// phase and stack-top loop sets that one-byte-per-cycle rate.
// A two-entry queue sits between the front and back ends and the result is
// held in an output register, so either side may stall independently.
// Nesting is limited to 16 maps or lists; the stack needs no clearing pass.
`include "binary_object_stream_tokenizer_assert.svh"

module binary_object_stream_tokenizer (
   input  logic         clock,
   input  logic         reset,
   // input byte channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // byte_in
   input  logic         req_tuser,   // doc_start
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata    // byte_role[2:0], token_kind[6:3],
                                     // payload_length[34:7], scalar_value[98:35],
                                     // value_done[99], container_end[100],
                                     // nest_level[105:101], error_code[107:106],
                                     // doc_done[108], zero fill
);
   import bost_pkg::*;

   // queue between classify and execute
   logic     q_valid, q_ready;
   item_type q_item;
   rsp_type  rsp;

   bost_front u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_data      (req_tdata),
      .in_doc_start (req_tuser),
      .out_valid    (q_valid),
      .out_ready    (q_ready),
      .out_item     (q_item)
   );

   // state machine and output register
   bost_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {3'd0, rsp};

   // depth never goes past the stack size
   `BOST_ASSERT(a_nest_bound, clock, reset, rsp_tvalid |-> (rsp.nest_level <= MAX_NEST_V))
   // an error result carries no role, kind or flags
   `BOST_ASSERT(a_err_quiet, clock, reset,
      (rsp_tvalid && rsp.error_code != ERR_NONE) |->
      (rsp.byte_role == ROLE_HEADER && rsp.token_kind == KIND_NULL && !rsp.value_done))
   // a closed container is always a completed end token
   `BOST_ASSERT(a_end_done, clock, reset,
      (rsp_tvalid && rsp.container_end) |-> (rsp.value_done && rsp.token_kind == KIND_END))
   // queue is never full and empty at once
   `BOST_ASSERT_ALWAYS(a_queue_hs, clock, !reset |-> (req_tready || q_valid))

endmodule

// ----- tb/sv/tb_binary_object_stream_tokenizer.sv -----
`timescale 1ns / 100ps

module tb_binary_object_stream_tokenizer;
   import bost_pkg::*;

   // predictor of the tokenizer plus the queue of expected token reports
   class token_scoreboard;
      rsp_type    expected_q[$];
      int         errors;
      phase_type  ph;
      logic [7:0] hdr;
      logic [27:0] remain;
      logic [27:0] total_len;
      logic [1:0] len_left;
      logic [63:0] accum;
      logic [3:0] val_left;
      logic       stack[MAX_NEST];
      logic [4:0] depth;
      err_type    held;

      function new();
         errors = 0;
         clear();
      endfunction

      function void clear();
         ph = PH_HDR;
         hdr = '0;
         remain = '0;
         total_len = '0;
         len_left = '0;
         accum = '0;
         val_left = '0;
         depth = '0;
         held = ERR_NONE;
      endfunction

      function kind_type kind_of(input logic [3:0] n);
         case (n)
            4'h0: return KIND_END;
            4'h1: return KIND_NULL;
            4'h2: return KIND_TRUE;
            4'h3: return KIND_FALSE;
            4'h4: return KIND_BYTE;
            4'h5: return KIND_I32;
            4'h6: return KIND_I64;
            4'h7: return KIND_U32;
            4'h8: return KIND_U64;
            4'hA: return KIND_DOUBLE;
            4'hB: return KIND_DATETIME;
            4'hC: return KIND_MAP;
            4'hD: return KIND_LIST;
            default: return KIND_BAD;
         endcase
      endfunction

      function logic [3:0] size_of(input logic [3:0] n);
         case (n)
            4'h4: return 4'd1;
            4'h5, 4'h7: return 4'd4;
            4'h6, 4'h8, 4'hA, 4'hB: return 4'd8;
            default: return 4'd0;
         endcase
      endfunction

      // a value is complete: go back to headers or to the key of the enclosing map
      function void close_value(ref rsp_type r);
         r.value_done = 1'b1;
         if (depth == 0) begin
            r.doc_done = 1'b1;
            ph = PH_HDR;
         end else if (stack[depth - 1]) begin
            ph = PH_KEY;
         end else begin
            ph = PH_HDR;
         end
      endfunction

      // predict the report for one accepted byte transfer
      function void note_byte(input logic [7:0] b, input logic start);
         rsp_type    r;
         kind_type   k;
         logic [3:0] sz;
         logic [31:0] sh;
         int         idx;
         if (start) clear();
         r = '0;
         r.byte_role = ROLE_HEADER;
         r.token_kind = KIND_NULL;
         r.error_code = ERR_NONE;
         if (held != ERR_NONE) begin
            r.error_code = held;
         end else begin
            case (ph)
               PH_HDR: begin
                  hdr = b;
                  if (b[7]) begin
                     r.token_kind = b[6] ? KIND_STRING : KIND_BLOB;
                     r.payload_length = 28'(b[5:0]);
                     if (b[5:0] != 0) begin
                        total_len = 28'(b[5:0]);
                        remain = 28'(b[5:0]);
                        ph = PH_PAY;
                     end else begin
                        close_value(r);
                     end
                  end else if (b[7:4] != 0) begin
                     if (b[5:4] == 0) begin
                        held = ERR_LENGTH;
                        r.error_code = ERR_LENGTH;
                     end else begin
                        r.token_kind = b[6] ? KIND_STRING : KIND_BLOB;
                        remain = 28'(b[3:0]);
                        len_left = b[5:4];
                        ph = PH_LEN;
                     end
                  end else begin
                     k = kind_of(b[3:0]);
                     if (k == KIND_BAD) begin
                        held = ERR_TOKEN;
                        r.error_code = ERR_TOKEN;
                     end else if (b == B_END) begin
                        r.token_kind = KIND_END;
                        if (depth == 0) begin
                           r.doc_done = 1'b1;
                        end else begin
                           depth--;
                           r.container_end = 1'b1;
                           close_value(r);
                        end
                     end else if (b == B_MAP || b == B_LIST) begin
                        if (depth >= MAX_NEST) begin
                           held = ERR_NEST;
                           r.error_code = ERR_NEST;
                        end else begin
                           r.token_kind = k;
                           stack[depth] = (b == B_MAP);
                           depth++;
                        end
                     end else begin
                        r.token_kind = k;
                        sz = size_of(b[3:0]);
                        if (sz != 0) begin
                           accum = '0;
                           val_left = sz;
                           ph = PH_SCAL;
                        end else begin
                           close_value(r);
                        end
                     end
                  end
               end
               PH_LEN: begin
                  idx = int'(hdr[5:4]) - int'(len_left);
                  r.byte_role = ROLE_LENGTH;
                  r.token_kind = hdr[6] ? KIND_STRING : KIND_BLOB;
                  sh = 32'(b) << (4 + 8 * idx);
                  remain = remain | sh[27:0];
                  len_left--;
                  if (len_left == 0) begin
                     r.payload_length = remain;
                     if (remain == 0) begin
                        close_value(r);
                     end else begin
                        total_len = remain;
                        ph = PH_PAY;
                     end
                  end
               end
               PH_PAY: begin
                  r.byte_role = ROLE_PAYLOAD;
                  r.token_kind = hdr[6] ? KIND_STRING : KIND_BLOB;
                  r.payload_length = total_len;
                  remain--;
                  if (remain == 0) close_value(r);
               end
               PH_SCAL: begin
                  idx = int'(size_of(hdr[3:0])) - int'(val_left);
                  r.byte_role = ROLE_SCALAR;
                  r.token_kind = kind_of(hdr[3:0]);
                  accum = accum | (64'(b) << (8 * idx));
                  r.scalar_value = accum;
                  val_left--;
                  if (val_left == 0) close_value(r);
               end
               default: begin
                  if (b == 8'h00) begin
                     r.byte_role = ROLE_KEY_END;
                     ph = PH_HDR;
                  end else begin
                     r.byte_role = ROLE_KEY;
                  end
               end
            endcase
         end
         r.nest_level = depth;
         expected_q.push_back(r);
      endfunction

      function void cmp(input string name, input logic [63:0] e, input logic [63:0] a);
         if (e !== a) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
            errors++;
         end
      endfunction

      // compare one result transfer with the oldest expectation
      function void check_report(input logic [111:0] data);
         rsp_type a, e;
         a = rsp_type'(data[108:0]);
         if (expected_q.size() == 0) begin
            $display("%0t unexpected result transfer: expected none actual %0h", $time, data);
            errors++;
            return;
         end
         e = expected_q.pop_front();
         cmp("byte_role", 64'(e.byte_role), 64'(a.byte_role));
         cmp("token_kind", 64'(e.token_kind), 64'(a.token_kind));
         cmp("payload_length", 64'(e.payload_length), 64'(a.payload_length));
         cmp("scalar_value", e.scalar_value, a.scalar_value);
         cmp("value_done", 64'(e.value_done), 64'(a.value_done));
         cmp("container_end", 64'(e.container_end), 64'(a.container_end));
         cmp("nest_level", 64'(e.nest_level), 64'(a.nest_level));
         cmp("error_code", 64'(e.error_code), 64'(a.error_code));
         cmp("doc_done", 64'(e.doc_done), 64'(a.doc_done));
         cmp("zero fill", 64'(0), 64'(data[111:109]));
      endfunction
   endclass

   localparam int ITEMS = 1150;
   localparam int LIMIT = 400000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [7:0]   req_tdata;   // byte_in
   logic         req_tuser;   // doc_start
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [111:0] rsp_tdata;   // byte_role .. doc_done, see block ports

   token_scoreboard sb;
   logic [7:0] byte_q[$];     // stream bytes to send
   logic       start_q[$];    // doc_start per byte
   int         idle_pct;      // sender idle chance of the current phase
   int         stall_pct;     // receiver stall chance of the current phase
   int         cycles;

   binary_object_stream_tokenizer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stream building helpers
   function automatic void put(input logic [7:0] b, input logic s = 1'b0);
      byte_q.push_back(b);
      start_q.push_back(s);
   endfunction

   // zero-terminated key of random nonzero chars
   function automatic void gen_key();
      int n;
      n = $urandom_range(0, 4);
      repeat (n) put(8'($urandom_range(1, 255)));
      put(8'h00);
   endfunction

   // one random well-formed value, nesting allowed while depth is small
   function automatic void gen_value(input int depth);
      int sel, n, len;
      logic [7:0] h;
      sel = $urandom_range(0, 99);
      if (sel < 20) begin
         // short string or blob, mostly short payloads
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 6);
         put({1'b1, 1'($urandom), 6'(len)});
         repeat (len) put(8'($urandom));
      end else if (sel < 32) begin
         // long form: low nibble plus 1 to 3 extension bytes, kept small
         n = $urandom_range(1, 3);
         h = {1'b0, 1'($urandom), 2'(n), 4'($urandom)};
         put(h);
         len = h[3:0];
         for (int i = 0; i < n; i++) begin
            if (i == 0) begin
               put(8'($urandom_range(0, 2)));
               len += int'(byte_q[$]) << 4;
            end else begin
               put(8'h00);
            end
         end
         repeat (len) put(8'($urandom));
      end else if (sel < 62) begin
         // scalars and constants
         case ($urandom_range(0, 10))
            0: h = 8'h01;
            1: h = 8'h02;
            2: h = 8'h03;
            3: h = 8'h04;
            4: h = 8'h05;
            5: h = 8'h06;
            6: h = 8'h07;
            7: h = 8'h08;
            8: h = 8'h0A;
            default: h = 8'h0B;
         endcase
         put(h);
         case (h)
            8'h04: n = 1;
            8'h05, 8'h07: n = 4;
            8'h06, 8'h08, 8'h0A, 8'h0B: n = 8;
            default: n = 0;
         endcase
         repeat (n) put(8'($urandom));
      end else if (depth < 4 || $urandom_range(0, 9) == 0) begin
         // map or list with a few entries
         h = $urandom_range(0, 1) ? B_MAP : B_LIST;
         put(h);
         n = (depth > 6) ? $urandom_range(0, 1) : $urandom_range(0, 3);
         repeat (n) begin
            gen_value(depth + 1);
            if (h == B_MAP) gen_key();
         end
         put(B_END);
      end else begin
         put(8'h01);
      end
   endfunction

   // directed opening part
   function automatic void gen_directed();
      put(8'h01, 1'b1);                       // null
      put(8'h02); put(8'h03);                 // booleans
      put(8'h04); put(8'hFF);                 // byte, all ones
      put(8'h05); put(8'h00); put(8'h00); put(8'h00); put(8'h80);
      put(8'hC0);                             // empty short string
      put(8'h80);                             // empty short blob
      put(8'h10); put(8'h00);                 // zero length long form
      put(B_END);                             // end at top level
      put(8'h0C); put(8'h01); put(8'h41); put(8'h00); put(B_END);
      put(8'h09);                             // invalid header, sticky
      put(8'hFF);
      put(8'h0E, 1'b1);
      put(8'h0F, 1'b1);
      put(8'h40, 1'b1);                       // long form without extension
      put(8'h4F, 1'b1);
      put(B_LIST, 1'b1);                      // nesting one past the limit
      repeat (MAX_NEST) put(B_LIST);
      put(8'h01);
      put(8'hFF, 1'b1);                       // 63-byte string
      repeat (63) put(8'($urandom));
   endfunction

   // random part: mostly well-formed documents, some noise and broken ones
   function automatic void gen_random();
      int sel;
      while (byte_q.size() < ITEMS) begin
         sel = $urandom_range(0, 99);
         if (sel < 80) begin
            start_q.push_back(1'b0);
            byte_q.push_back(8'h00);
            void'(byte_q.pop_back());
            void'(start_q.pop_back());
            begin
               int first;
               first = byte_q.size();
               gen_value(0);
               start_q[first] = ($urandom_range(0, 3) != 0);
            end
         end else if (sel < 90) begin
            // noise bytes
            repeat ($urandom_range(1, 8)) put(8'($urandom), 1'($urandom_range(0, 3) == 0));
         end else if (sel < 95) begin
            // deep nesting up to overflow
            put(B_MAP, 1'b1);
            repeat ($urandom_range(10, 17)) put($urandom_range(0, 1) ? B_MAP : B_LIST);
         end else begin
            // truncated document, then a fresh start
            put(8'h06, 1'b1);
            put(8'($urandom));
         end
         // recover from whatever came before
         put(8'h02, 1'b1);
      end
   endfunction

   // receiver ready, changed at the falling edge
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // result monitor at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_report(rsp_tdata);
   end

   // cycle limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // send one byte and wait for its transfer
   task automatic send_byte(input logic [7:0] b, input logic s);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= s;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(b, s);
      @(negedge clock);
   endtask

   initial begin
      int total;
      sb = new();
      cycles = 0;
      idle_pct = 0;
      stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      gen_directed();
      gen_random();
      total = byte_q.size();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      for (int i = 0; i < total; i++) begin
         // four idling phases over the run
         case (i * 4 / total)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 47; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 47; end
            default: begin idle_pct = 35; stall_pct = 35; end
         endcase
         send_byte(byte_q[i], start_q[i]);
      end
      req_tvalid <= 1'b0;
      idle_pct = 0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
